// ===== rtl/core/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and helpers of the PNG scanline unfilter block.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int unsigned MAX_ROW_BYTES   = 32768;
  localparam int unsigned MAX_PIXEL_BYTES = 8;

  // Row store address, row length and history index widths
  localparam int unsigned ROW_AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned RB_W   = ROW_AW + 1;
  localparam int unsigned LEN_W  = (RB_W > 16) ? RB_W : 16;
  localparam int unsigned BPP_IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  localparam int unsigned BPP_W  = 4;
  localparam int unsigned ROWB_W = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTES_PER_PIXEL = 1'b0,
    CFG_ROW_BYTES       = 1'b1
  } psu_cfg_idx_e;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } psu_filter_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } psu_in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } psu_out_t;

  // One word on its way from the sequencer to the reconstruction stage
  typedef struct packed {
    logic              bad;
    psu_filter_e       filter;
    logic              first_row;
    logic              row_end;
    logic [ROW_AW-1:0] pos;
    logic [7:0]        data;
  } psu_item_t;

  typedef struct packed {
    logic      valid;
    logic      clr_hist;
    psu_item_t item;
  } psu_issue_t;

  // Effective row length: zero reads as one, saturate at the row store depth
  function automatic logic [RB_W-1:0] row_len(logic [ROWB_W-1:0] rb);
    logic [LEN_W-1:0] r;
    r = LEN_W'(rb);
    if (r == '0) begin
      r = LEN_W'(1);
    end else if (r > LEN_W'(MAX_ROW_BYTES)) begin
      r = LEN_W'(MAX_ROW_BYTES);
    end
    return RB_W'(r);
  endfunction

  // History tap of the left neighbor: distance clamped to 1..MAX_PIXEL_BYTES
  function automatic logic [BPP_IW-1:0] bpp_index(logic [BPP_W-1:0] bpp);
    logic [BPP_W:0] b;
    b = {1'b0, bpp};
    if (b == '0) begin
      b = (BPP_W + 1)'(1);
    end else if (b > (BPP_W + 1)'(MAX_PIXEL_BYTES)) begin
      b = (BPP_W + 1)'(MAX_PIXEL_BYTES);
    end
    b = b - (BPP_W + 1)'(1);
    return BPP_IW'(b);
  endfunction

endpackage

// ===== rtl/core/psu_ram.sv =====
// ----------------------------------------------------------------------------
// psu_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module psu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/psu_ctrl.sv =====
// ----------------------------------------------------------------------------
// psu_ctrl
// Stream sequencer: parses filter type bytes, tracks the byte position in
// the row and issues data words and row store reads to reconstruction.
// ----------------------------------------------------------------------------
module psu_ctrl
  import psu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  psu_in_t           in_word_i,
  input  logic [ROWB_W-1:0] row_bytes_i,
  input  logic              s1_free_i,
  output psu_issue_t        issue_o,
  output logic              rd_en_o,
  output logic [ROW_AW-1:0] rd_addr_o
);

  logic              halted_q, halted_d;
  logic              await_q, await_d;
  logic              first_q, first_d;
  psu_filter_e       filter_q, filter_d;
  logic [ROW_AW-1:0] pos_q, pos_d;

  logic              accept;
  logic              sof;
  logic              eff_halt, eff_await, eff_first;
  logic [ROW_AW-1:0] eff_pos;
  logic [RB_W-1:0]   pos_next;
  logic              last;

  assign in_stall_o = !s1_free_i;
  assign accept     = in_valid_i && s1_free_i;
  assign sof        = in_word_i.start_of_image;

  // Start of image drops the row in progress and releases a halt
  assign eff_halt  = sof ? 1'b0 : halted_q;
  assign eff_await = sof ? 1'b1 : await_q;
  assign eff_first = sof ? 1'b1 : first_q;
  assign eff_pos   = sof ? '0 : pos_q;

  assign pos_next = {1'b0, eff_pos} + RB_W'(1);
  assign last     = pos_next >= row_len(row_bytes_i);

  always_comb begin
    halted_d = halted_q;
    await_d  = await_q;
    first_d  = first_q;
    filter_d = filter_q;
    pos_d    = pos_q;
    issue_o  = '0;
    issue_o.item.filter    = filter_q;
    issue_o.item.first_row = eff_first;
    issue_o.item.pos       = eff_pos;
    issue_o.item.data      = in_word_i.data_byte;
    issue_o.item.row_end   = last;
    rd_en_o  = 1'b0;
    if (accept && !eff_halt) begin
      halted_d = 1'b0;
      first_d  = eff_first;
      if (eff_await) begin
        issue_o.clr_hist = 1'b1;
        pos_d            = '0;
        if (in_word_i.data_byte > 8'(FILT_PAETH)) begin
          halted_d           = 1'b1;
          await_d            = 1'b1;
          issue_o.valid      = 1'b1;
          issue_o.item.bad   = 1'b1;
        end else begin
          filter_d = psu_filter_e'(in_word_i.data_byte[2:0]);
          await_d  = 1'b0;
        end
      end else begin
        issue_o.valid = 1'b1;
        rd_en_o       = 1'b1;
        if (last) begin
          await_d = 1'b1;
          first_d = 1'b0;
          pos_d   = '0;
        end else begin
          pos_d = pos_next[ROW_AW-1:0];
        end
      end
    end
  end

  assign rd_addr_o = eff_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      await_q  <= 1'b1;
      first_q  <= 1'b1;
      filter_q <= FILT_NONE;
      pos_q    <= '0;
    end else begin
      halted_q <= halted_d;
      await_q  <= await_d;
      first_q  <= first_d;
      filter_q <= filter_d;
      pos_q    <= pos_d;
    end
  end

endmodule

// ===== rtl/core/psu_recon.sv =====
// ----------------------------------------------------------------------------
// psu_recon
// Reconstruction stage: takes the row store read data, applies the row's
// filter, writes the byte back to the row store and holds the output word.
// ----------------------------------------------------------------------------
module psu_recon
  import psu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psu_issue_t        issue_i,
  input  logic [BPP_IW-1:0] bpp_idx_i,
  input  logic [7:0]        rd_data_i,
  output logic              s1_free_o,
  output logic              wr_en_o,
  output logic [ROW_AW-1:0] wr_addr_o,
  output logic [7:0]        wr_data_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psu_out_t          out_word_o
);

  logic      s1_valid_q;
  psu_item_t s1_q;
  logic      fwd_q;
  logic [7:0] fwd_data_q;

  logic [7:0] left_q   [MAX_PIXEL_BYTES];
  logic [7:0] upleft_q [MAX_PIXEL_BYTES];

  logic       out_valid_q;
  psu_out_t   out_q;

  logic       s1_adv;
  logic [7:0] a, b, c;
  logic [7:0] pred, val;
  logic [8:0] ab_sum;
  logic [9:0] ab_w, cc_w;
  logic [7:0] pa, pb;
  logic [9:0] pc;
  psu_out_t   res;

  assign s1_adv    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_free_o = !s1_valid_q || s1_adv;

  assign a = left_q[bpp_idx_i];
  assign c = upleft_q[bpp_idx_i];
  // Take the byte being written when the read hit the same entry
  assign b = s1_q.first_row ? 8'd0 : (fwd_q ? fwd_data_q : rd_data_i);

  assign ab_sum = {1'b0, a} + {1'b0, b};
  assign ab_w   = {1'b0, ab_sum};
  assign cc_w   = {1'b0, c, 1'b0};
  assign pa     = (b >= c) ? b - c : c - b;
  assign pb     = (a >= c) ? a - c : c - a;
  assign pc     = (ab_w >= cc_w) ? ab_w - cc_w : cc_w - ab_w;

  always_comb begin
    case (s1_q.filter)
      FILT_SUB: pred = a;
      FILT_UP:  pred = b;
      FILT_AVG: pred = ab_sum[8:1];
      FILT_PAETH: begin
        if ({2'b00, pa} <= {2'b00, pb} && {2'b00, pa} <= pc) begin
          pred = a;
        end else if ({2'b00, pb} <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:  pred = 8'd0;
    endcase
  end

  assign val = s1_q.data + pred;

  always_comb begin
    res = '0;
    if (s1_q.bad) begin
      res.bad_filter = 1'b1;
    end else begin
      res.pixel_byte = val;
      res.row_end    = s1_q.row_end;
    end
  end

  assign wr_en_o   = s1_adv && !s1_q.bad;
  assign wr_addr_o = s1_q.pos;
  assign wr_data_o = val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue_i.valid) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.valid) begin
      s1_q       <= issue_i.item;
      fwd_q      <= wr_en_o && (wr_addr_o == issue_i.item.pos);
      fwd_data_q <= val;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // Histories, newest first; a filter type byte clears them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i]   <= 8'd0;
        upleft_q[i] <= 8'd0;
      end
    end else if (issue_i.clr_hist) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_q[i]   <= 8'd0;
        upleft_q[i] <= 8'd0;
      end
    end else if (s1_adv && !s1_q.bad) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_q[i]   <= left_q[i-1];
        upleft_q[i] <= upleft_q[i-1];
      end
      left_q[0]   <= val;
      upleft_q[0] <= b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/core/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth).
// ----------------------------------------------------------------------------
// The block takes one byte of the inflated stream per clock, back to back,
// while the output is not stalled, and returns one reconstructed byte per
// filtered data byte; filter type bytes give no word unless the type is
// above 4, which gives one word with bad_filter set and halts the block until
// the next start_of_image. The rate is set by the row store: a 32768 x 8 RAM
// read once for the byte above and written once with the rebuilt byte per
// data byte. A byte is registered in the recon stage, then in the output word.
// The row store is never cleared; an image's first row writes all it reads.
// Write bytes_per_pixel and row_bytes only while the block is idle.
// ----------------------------------------------------------------------------
module png_scanline_unfilter
  import psu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  psu_in_t              in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output psu_out_t             out_word_o
);

  logic [BPP_W-1:0]  bpp_q;
  logic [ROWB_W-1:0] row_bytes_q;

  psu_issue_t        issue;
  logic              s1_free;
  logic              rd_en;
  logic [ROW_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic [ROW_AW-1:0] wr_addr;
  logic [7:0]        wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q       <= BPP_W'(1);
      row_bytes_q <= ROWB_W'(1);
    end else if (cfg_we_i) begin
      case (psu_cfg_idx_e'(cfg_idx_i))
        CFG_BYTES_PER_PIXEL: bpp_q       <= cfg_data_i[BPP_W-1:0];
        CFG_ROW_BYTES:       row_bytes_q <= cfg_data_i[ROWB_W-1:0];
        default: ;
      endcase
    end
  end

  psu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .row_bytes_i (row_bytes_q),
    .s1_free_i   (s1_free),
    .issue_o     (issue),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr)
  );

  psu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  psu_recon u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .bpp_idx_i   (bpp_index(bpp_q)),
    .rd_data_i   (rd_data),
    .s1_free_o   (s1_free),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/core/psu_checker.sv =====
// ----------------------------------------------------------------------------
// psu_checker
// Port-level checks of the PNG scanline unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module psu_checker
  import psu_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input psu_in_t  in_word_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input psu_out_t out_word_o
);

  // Input backs up only when the output holds a word that is not taken
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  // An error word carries no pixel and no row end
  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.bad_filter) |->
      (out_word_o.pixel_byte == 8'd0 && !out_word_o.row_end))
    else $error("error word with pixel data");

  // No output word is valid in the cycle in which reset is seen to rise
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output word right after reset");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
